### rtl/dcm_pkg.sv
// Package for the DC motor forward Euler model.
// Holds the controller states, multiply modes, command and status bundles and constants.
// No dependencies; every file of the block but the checker imports it.
package dcm_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRICTION_COEFF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_INERTIA    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENCODER_SCALE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSTEPS       = 3'd5;

    // Reset values of the configuration registers.
    localparam logic signed [31:0] TORQUE_GAIN_RST    = 32'sd16777216;
    localparam logic signed [31:0] FRICTION_COEFF_RST = 32'sd0;
    localparam logic [30:0]        INV_INERTIA_RST    = 31'd16777216;
    localparam logic [30:0]        TIME_STEP_RST      = 31'd16777;
    localparam logic signed [31:0] ENCODER_SCALE_RST  = 32'sd16777216;
    localparam logic [7:0]         SUBSTEPS_RST       = 8'd1;

    // Upper bound on the substep count of one command.
    localparam int MAX_SUBSTEPS = 255;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TORQUE,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } state_t;

    // Shared unit multiplications in order: four per substep, then two for encoder scaling.
    typedef enum logic [2:0] {
        OP_FRIC,
        OP_ACCEL,
        OP_DVEL,
        OP_DPOS,
        OP_EPOS,
        OP_EVEL
    } op_t;

    // Scaling of the multiply unit: right shift and saturation width.
    typedef enum logic [1:0] {
        MUL_Q24_W60,
        MUL_Q24_W48,
        MUL_Q32_W48
    } mul_mode_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_take;
        logic torque_load;
        logic mul_start;
        op_t  op;
        logic out_load;
    } dcm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       mul_done;
        logic       out_free;
        logic [7:0] sub_n;
    } dcm_sts_t;

    // Saturate a 62-bit signed value to 48-bit signed.
    function automatic logic signed [47:0] sat48(input logic signed [61:0] v);
        logic signed [47:0] r;
        if (v[61:47] == {15{v[61]}})
        begin
            r = v[47:0];
        end
        else if (v[61])
        begin
            r = {1'b1, {47{1'b0}}};
        end
        else
        begin
            r = {1'b0, {47{1'b1}}};
        end
        return r;
    endfunction

endpackage

### rtl/dcm_mul.sv
// Shared multi-cycle signed multiplier with floor shift and saturation.
// One 32x32 unsigned multiplier is used twice per operation (low and high half of A).
// Depends on dcm_pkg.
module dcm_mul
    import dcm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [31:0] b,
    input  mul_mode_t          mode,
    output logic               done,
    output logic signed [59:0] res
);

    logic [4:0]         v_reg;
    logic [4:0]         v_next;
    logic [63:0]        mag_a_reg;
    logic [31:0]        mag_b_reg;
    logic               neg_reg;
    mul_mode_t          mode_reg;
    logic [63:0]        pp0_reg;
    logic [63:0]        pp1_reg;
    logic [95:0]        sum_reg;
    logic signed [59:0] res_reg;

    logic [31:0]        half;
    logic [63:0]        prod;
    logic [95:0]        rmask;
    logic [95:0]        sum_val;
    logic [71:0]        q;
    logic               over;
    logic [59:0]        lim;
    logic [59:0]        sat_mag;
    logic signed [59:0] res_val;

    // Stage tracking: load, low product, high product, sum, saturate.
    assign v_next = {v_reg[3:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // One multiplier, fed the low half of |A| first and the high half next.
    assign half = v_reg[1] ? mag_a_reg[63:32] : mag_a_reg[31:0];
    assign prod = {32'd0, half} * {32'd0, mag_b_reg};

    // Negative products add the shifted-out ones so the truncation floors.
    always_comb
    begin
        rmask = '0;
        if (neg_reg)
        begin
            if (mode_reg == MUL_Q32_W48)
            begin
                rmask = {64'd0, 32'hFFFF_FFFF};
            end
            else
            begin
                rmask = {72'd0, 24'hFF_FFFF};
            end
        end
    end

    assign sum_val = {32'd0, pp0_reg} + {pp1_reg, 32'd0} + rmask;

    // Shift, range check and sign restore.
    always_comb
    begin
        case (mode_reg)
            MUL_Q24_W60:
            begin
                q    = sum_reg[95:24];
                over = |sum_reg[95:83];
                lim  = {1'b1, 59'd0};
            end
            MUL_Q24_W48:
            begin
                q    = sum_reg[95:24];
                over = |sum_reg[95:71];
                lim  = {12'd0, 1'b1, 47'd0};
            end
            MUL_Q32_W48:
            begin
                q    = {8'd0, sum_reg[95:32]};
                over = |sum_reg[95:79];
                lim  = {12'd0, 1'b1, 47'd0};
            end
            default:
            begin
                q    = sum_reg[95:24];
                over = |sum_reg[95:83];
                lim  = {1'b1, 59'd0};
            end
        endcase
        if (over)
        begin
            sat_mag = neg_reg ? lim : (lim - 60'd1);
        end
        else
        begin
            sat_mag = q[59:0];
        end
        res_val = neg_reg ? -$signed(sat_mag) : $signed(sat_mag);
    end

    // Operand and pipeline data registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_a_reg <= a[63] ? (~a + 64'd1) : a;
            mag_b_reg <= b[31] ? (~b + 32'd1) : b;
            neg_reg   <= a[63] ^ b[31];
            mode_reg  <= mode;
        end
        if (v_reg[0])
        begin
            pp0_reg <= prod;
        end
        if (v_reg[1])
        begin
            pp1_reg <= prod;
        end
        if (v_reg[2])
        begin
            sum_reg <= sum_val;
        end
        if (v_reg[3])
        begin
            res_reg <= res_val;
        end
    end

    assign done = v_reg[4];
    assign res  = res_reg;

endmodule

### rtl/dcm_datapath.sv
// Datapath of the DC motor model: configuration, motor state, operand selection,
// result commit and the output register. Depends on dcm_pkg and dcm_mul.
module dcm_datapath
    import dcm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  has_command,
    input  logic signed [15:0]    current_command,
    input  dcm_cmd_t              cmd,
    output dcm_sts_t              sts,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic signed [47:0]    encoder_position,
    output logic signed [47:0]    encoder_velocity,
    output logic signed [15:0]    current_echo
);

    // Configuration registers.
    logic signed [31:0] torque_gain_reg;
    logic signed [31:0] friction_coeff_reg;
    logic [30:0]        inv_inertia_reg;
    logic [30:0]        time_step_reg;
    logic signed [31:0] encoder_scale_reg;
    logic [7:0]         substeps_reg;

    // Motor state and intermediates.
    logic signed [47:0] velocity_reg;
    logic signed [47:0] velocity_next;
    logic [63:0]        position_reg;
    logic [63:0]        position_next;
    logic signed [15:0] last_current_reg;
    logic signed [47:0] held_pos_reg;
    logic signed [47:0] held_pos_next;
    logic signed [47:0] held_vel_reg;
    logic signed [47:0] held_vel_next;
    logic signed [47:0] torque_reg;
    logic signed [47:0] eff_reg;
    logic signed [47:0] eff_next;
    logic signed [47:0] acc_reg;
    logic signed [47:0] acc_next;

    // Output register.
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [47:0] out_pos_reg;
    logic signed [47:0] out_vel_reg;
    logic signed [15:0] out_cur_reg;

    // Multiply unit connections.
    logic signed [63:0] mul_a;
    logic signed [31:0] mul_b;
    mul_mode_t          mul_mode;
    logic               mul_done;
    logic signed [59:0] mul_res;

    dcm_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .mode  (mul_mode),
        .done  (mul_done),
        .res   (mul_res)
    );

    // Operand selection for the current multiplication.
    always_comb
    begin
        case (cmd.op)
            OP_FRIC:
            begin
                mul_a    = {{16{velocity_reg[47]}}, velocity_reg};
                mul_b    = friction_coeff_reg;
                mul_mode = MUL_Q24_W60;
            end
            OP_ACCEL:
            begin
                mul_a    = {{16{eff_reg[47]}}, eff_reg};
                mul_b    = {1'b0, inv_inertia_reg};
                mul_mode = MUL_Q24_W48;
            end
            OP_DVEL:
            begin
                mul_a    = {{16{acc_reg[47]}}, acc_reg};
                mul_b    = {1'b0, time_step_reg};
                mul_mode = MUL_Q24_W60;
            end
            OP_DPOS:
            begin
                mul_a    = {{16{velocity_reg[47]}}, velocity_reg};
                mul_b    = {1'b0, time_step_reg};
                mul_mode = MUL_Q24_W60;
            end
            OP_EPOS:
            begin
                mul_a    = position_reg;
                mul_b    = encoder_scale_reg;
                mul_mode = MUL_Q32_W48;
            end
            OP_EVEL:
            begin
                mul_a    = {{16{velocity_reg[47]}}, velocity_reg};
                mul_b    = encoder_scale_reg;
                mul_mode = MUL_Q32_W48;
            end
            default:
            begin
                mul_a    = {{16{velocity_reg[47]}}, velocity_reg};
                mul_b    = friction_coeff_reg;
                mul_mode = MUL_Q24_W60;
            end
        endcase
    end

    // Commit of a finished product into its destination.
    always_comb
    begin
        eff_next      = eff_reg;
        acc_next      = acc_reg;
        velocity_next = velocity_reg;
        position_next = position_reg;
        held_pos_next = held_pos_reg;
        held_vel_next = held_vel_reg;
        if (mul_done)
        begin
            case (cmd.op)
                OP_FRIC:
                begin
                    eff_next = sat48({{14{torque_reg[47]}}, torque_reg}
                                     - {{2{mul_res[59]}}, mul_res});
                end
                OP_ACCEL:
                begin
                    acc_next = mul_res[47:0];
                end
                OP_DVEL:
                begin
                    velocity_next = sat48({{14{velocity_reg[47]}}, velocity_reg}
                                          + {{2{mul_res[59]}}, mul_res});
                end
                OP_DPOS:
                begin
                    position_next = position_reg + {{4{mul_res[59]}}, mul_res};
                end
                OP_EPOS:
                begin
                    held_pos_next = mul_res[47:0];
                end
                OP_EVEL:
                begin
                    held_vel_next = mul_res[47:0];
                end
                default:
                begin
                    eff_next = eff_reg;
                end
            endcase
        end
    end

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            torque_gain_reg    <= TORQUE_GAIN_RST;
            friction_coeff_reg <= FRICTION_COEFF_RST;
            inv_inertia_reg    <= INV_INERTIA_RST;
            time_step_reg      <= TIME_STEP_RST;
            encoder_scale_reg  <= ENCODER_SCALE_RST;
            substeps_reg       <= SUBSTEPS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TORQUE_GAIN:    torque_gain_reg    <= cfg_data;
                CFG_FRICTION_COEFF: friction_coeff_reg <= cfg_data;
                CFG_INV_INERTIA:    inv_inertia_reg    <= cfg_data[30:0];
                CFG_TIME_STEP:      time_step_reg      <= cfg_data[30:0];
                CFG_ENCODER_SCALE:  encoder_scale_reg  <= cfg_data;
                CFG_SUBSTEPS:       substeps_reg       <= cfg_data[7:0];
                default:            substeps_reg       <= substeps_reg;
            endcase
        end
    end

    // Motor state, held encoder values and last command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            velocity_reg     <= '0;
            position_reg     <= '0;
            last_current_reg <= '0;
            held_pos_reg     <= '0;
            held_vel_reg     <= '0;
        end
        else
        begin
            velocity_reg <= velocity_next;
            position_reg <= position_next;
            held_pos_reg <= held_pos_next;
            held_vel_reg <= held_vel_next;
            if (cmd.in_take && has_command)
            begin
                last_current_reg <= current_command;
            end
        end
    end

    // Working registers of a substep.
    always_ff @(posedge clk)
    begin
        if (cmd.torque_load)
        begin
            torque_reg <= 48'(last_current_reg) * 48'(torque_gain_reg);
        end
        eff_reg <= eff_next;
        acc_reg <= acc_next;
    end

    // Output register: a result waits here while the next item is taken.
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_pos_reg <= held_pos_reg;
            out_vel_reg <= held_vel_reg;
            out_cur_reg <= last_current_reg;
        end
    end

    // Status toward the controller.
    assign sts.mul_done = mul_done;
    assign sts.out_free = !out_valid_reg || !out_stall;
    assign sts.sub_n    = (int'(substeps_reg) > MAX_SUBSTEPS) ? 8'(MAX_SUBSTEPS)
                                                               : substeps_reg;

    assign out_valid        = out_valid_reg;
    assign encoder_position = out_pos_reg;
    assign encoder_velocity = out_vel_reg;
    assign current_echo     = out_cur_reg;

endmodule

### rtl/dcm_ctrl.sv
// Controller of the DC motor model: sequences torque, substeps and encoder scaling.
// Drives the datapath by a command bundle. Depends on dcm_pkg.
module dcm_ctrl
    import dcm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     has_command,
    output logic     in_stall,
    input  dcm_sts_t sts,
    output dcm_cmd_t cmd
);

    state_t     state_reg;
    state_t     state_next;
    op_t        op_reg;
    op_t        op_next;
    logic [7:0] cnt_reg;
    logic [7:0] cnt_next;

    // Next state, operation and remaining substep count.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (has_command)
                    begin
                        cnt_next   = sts.sub_n;
                        state_next = ST_TORQUE;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_TORQUE:
            begin
                op_next    = OP_FRIC;
                state_next = (cnt_reg == 8'd0) ? ST_OUT : ST_ISSUE;
            end
            ST_ISSUE:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (sts.mul_done)
                begin
                    state_next = ST_ISSUE;
                    case (op_reg)
                        OP_FRIC:  op_next = OP_ACCEL;
                        OP_ACCEL: op_next = OP_DVEL;
                        OP_DVEL:  op_next = OP_DPOS;
                        OP_DPOS:
                        begin
                            cnt_next = cnt_reg - 8'd1;
                            op_next  = (cnt_reg == 8'd1) ? OP_EPOS : OP_FRIC;
                        end
                        OP_EPOS:  op_next = OP_EVEL;
                        OP_EVEL:  state_next = ST_OUT;
                        default:  state_next = ST_OUT;
                    endcase
                end
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands and input handshake.
    always_comb
    begin
        cmd.in_take     = 1'b0;
        cmd.torque_load = 1'b0;
        cmd.mul_start   = 1'b0;
        cmd.op          = op_reg;
        cmd.out_load    = 1'b0;
        in_stall        = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.in_take = in_valid;
            end
            ST_TORQUE:
            begin
                cmd.torque_load = 1'b1;
            end
            ST_ISSUE:
            begin
                cmd.mul_start = 1'b1;
            end
            ST_WAIT:
            begin
                cmd.mul_start = 1'b0;
            end
            ST_OUT:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_FRIC;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### rtl/dc_motor_euler_model.sv
// Top level of the DC motor forward Euler model: controller plus datapath.
// Depends on dcm_pkg, dcm_ctrl, dcm_datapath (which holds dcm_mul).
//
//  Channel  Handshake               Payload
//  input    in_valid / in_stall     has_command, current_command
//  output   out_valid / out_stall   encoder_position, encoder_velocity, current_echo
//  config   cfg_write               cfg_index, cfg_data
//
// An item without a command goes straight to the output state to load its result.
// An item with a command and N substeps (1 to 255) loads the torque, then runs every
// product through the one shared 32x32 multiplier, four per substep and two for
// encoder scaling. With zero substeps the torque state leads straight to the output.
// One item is in work at a time; the next is taken in the cycle after a result is loaded.
// Reset is asynchronous; configuration and motor state return to their defaults.
// A stalled result waits in the output register; the block takes the next item meanwhile.
module dc_motor_euler_model
    import dcm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  has_command,
    input  logic signed [15:0]    current_command,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [47:0]    encoder_position,
    output logic signed [47:0]    encoder_velocity,
    output logic signed [15:0]    current_echo
);

    dcm_cmd_t cmd;
    dcm_sts_t sts;

    // Sequencer.
    dcm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .has_command (has_command),
        .in_stall    (in_stall),
        .sts         (sts),
        .cmd         (cmd)
    );

    // Arithmetic and storage.
    dcm_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .has_command      (has_command),
        .current_command  (current_command),
        .cmd              (cmd),
        .sts              (sts),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .encoder_position (encoder_position),
        .encoder_velocity (encoder_velocity),
        .current_echo     (current_echo)
    );

endmodule

### rtl/dcm_checker.sv
// Port-level checks for the DC motor model, attached to the top level by bind.
// Depends only on the top level's ports.
module dcm_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [47:0] encoder_position,
    input logic signed [47:0] encoder_velocity,
    input logic signed [15:0] current_echo
);

    // A taken item keeps the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("block took a second item right after the first");

    // The block frees its input only as it presents a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid)
    else $error("input freed without a result on the output");

    // A new result appears only while an item is in work.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(current_echo) |-> $past(in_stall))
    else $error("result changed while the block was idle");

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(encoder_position)
                                   && $stable(encoder_velocity)
                                   && $stable(current_echo))
    else $error("stalled result payload changed");

endmodule

bind dc_motor_euler_model dcm_checker u_dcm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .encoder_position (encoder_position),
    .encoder_velocity (encoder_velocity),
    .current_echo     (current_echo)
);

### sim/testbench.sv
// Testbench for the DC motor forward Euler model: directed and random command items.
// A per-item predictor of the motor state checks every result; depends on dcm_pkg and
// the dc_motor_euler_model RTL.
`timescale 1ns / 1ps

module testbench;
    import dcm_pkg::*;

    localparam int QUIET_LIMIT     = 25000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_ITEMS    = 1100;
    localparam int SETTLE_CYCLES   = 100;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    // Raw register values as they go onto the write port.
    typedef struct packed {
        logic [31:0] gain;
        logic [31:0] friction;
        logic [31:0] inv_inertia;
        logic [31:0] step;
        logic [31:0] scale;
        logic [31:0] substeps;
    } motor_cfg_t;

    // One encoder sample as the block should present it.
    typedef struct packed {
        logic signed [47:0] position;
        logic signed [47:0] velocity;
        logic signed [15:0] echo;
    } encoder_sample_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b1;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  has_command = 1'b0;
    logic signed [15:0]    current_command = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic signed [47:0]    encoder_position;
    logic signed [47:0]    encoder_velocity;
    logic signed [15:0]    current_echo;

    // Predicted configuration and motor state.
    logic signed [31:0] gain_q;
    logic signed [31:0] friction_q;
    logic [30:0]        inv_inertia_q;
    logic [30:0]        step_q;
    logic signed [31:0] scale_q;
    logic [7:0]         substeps_q;
    logic signed [47:0] rotor_vel;
    logic [63:0]        rotor_pos;
    logic signed [15:0] last_cmd;
    logic signed [47:0] held_pos;
    logic signed [47:0] held_vel;

    encoder_sample_t pending_samples[$];
    encoder_sample_t want_sample;

    int errors = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    always #6 clk = ~clk;

    dc_motor_euler_model dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .has_command      (has_command),
        .current_command  (current_command),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .encoder_position (encoder_position),
        .encoder_velocity (encoder_velocity),
        .current_echo     (current_echo)
    );

    // Exact product, floored shift, then saturation to a signed width.
    function automatic logic signed [63:0] mul_floor_sat(input logic signed [63:0] a,
                                                         input logic signed [63:0] b,
                                                         input int shift, input int width);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] prod;
        logic signed [127:0] lim_hi;
        logic signed [127:0] lim_lo;
        wa = 128'(a);
        wb = 128'(b);
        prod = (wa * wb) >>> shift;
        lim_hi = (128'sd1 <<< (width - 1)) - 128'sd1;
        lim_lo = -lim_hi - 128'sd1;
        if (prod > lim_hi)
        begin
            prod = lim_hi;
        end
        else if (prod < lim_lo)
        begin
            prod = lim_lo;
        end
        return prod[63:0];
    endfunction

    function automatic logic signed [47:0] clamp48(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > 64'sh0000_7fff_ffff_ffff)
        begin
            r = 64'sh0000_7fff_ffff_ffff;
        end
        else if (v < -64'sh0000_8000_0000_0000)
        begin
            r = -64'sh0000_8000_0000_0000;
        end
        return r[47:0];
    endfunction

    // Runs the motor for one accepted item and queues the sample it must produce.
    task automatic advance_motor(input logic cmd_present, input logic signed [15:0] cmd);
        logic signed [63:0] cmd64;
        logic signed [63:0] gain64;
        logic signed [63:0] fric64;
        logic signed [63:0] inv64;
        logic signed [63:0] step64;
        logic signed [63:0] scale64;
        logic signed [63:0] torque;
        logic signed [63:0] fr;
        logic signed [63:0] eff;
        logic signed [63:0] acc;
        logic signed [63:0] dv;
        logic signed [63:0] dp;
        logic signed [63:0] vel64;
        encoder_sample_t s;
        int n;
        if (cmd_present)
        begin
            gain64 = 64'(gain_q);
            fric64 = 64'(friction_q);
            inv64 = {33'd0, inv_inertia_q};
            step64 = {33'd0, step_q};
            scale64 = 64'(scale_q);
            last_cmd = cmd;
            cmd64 = 64'(cmd);
            torque = cmd64 * gain64;
            n = int'(substeps_q);
            if (n > MAX_SUBSTEPS)
            begin
                n = MAX_SUBSTEPS;
            end
            for (int i = 0; i < n; i++)
            begin
                vel64 = 64'(rotor_vel);
                fr = mul_floor_sat(vel64, fric64, 24, 60);
                eff = 64'(clamp48(torque - fr));
                acc = mul_floor_sat(eff, inv64, 24, 48);
                dv = mul_floor_sat(acc, step64, 24, 60);
                rotor_vel = clamp48(vel64 + dv);
                vel64 = 64'(rotor_vel);
                dp = mul_floor_sat(vel64, step64, 24, 60);
                rotor_pos = rotor_pos + dp;
            end
            // With no substeps only the echo moves.
            if (n > 0)
            begin
                vel64 = 64'(rotor_vel);
                held_pos = 48'(mul_floor_sat($signed(rotor_pos), scale64, 32, 48));
                held_vel = 48'(mul_floor_sat(vel64, scale64, 32, 48));
            end
        end
        s.position = held_pos;
        s.velocity = held_vel;
        s.echo = last_cmd;
        pending_samples.push_back(s);
    endtask

    // Offers one item, with random idle cycles first, and waits for it to be taken.
    task automatic drive_item(input logic cmd_present, input logic signed [15:0] cmd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        has_command <= cmd_present;
        current_command <= cmd;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        advance_motor(cmd_present, cmd);
    endtask

    // Stops offering and waits until every queued sample has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            CFG_TORQUE_GAIN:    gain_q = data;
            CFG_FRICTION_COEFF: friction_q = data;
            CFG_INV_INERTIA:    inv_inertia_q = data[30:0];
            CFG_TIME_STEP:      step_q = data[30:0];
            CFG_ENCODER_SCALE:  scale_q = data;
            CFG_SUBSTEPS:       substeps_q = data[7:0];
            default:            ;
        endcase
    endtask

    // Writes all six registers once the block is idle; optionally pokes unused indexes.
    task automatic load_motor_cfg(input motor_cfg_t c, input bit with_unused);
        wait_drained();
        write_reg(CFG_TORQUE_GAIN, c.gain);
        write_reg(CFG_FRICTION_COEFF, c.friction);
        write_reg(CFG_INV_INERTIA, c.inv_inertia);
        write_reg(CFG_TIME_STEP, c.step);
        write_reg(CFG_ENCODER_SCALE, c.scale);
        write_reg(CFG_SUBSTEPS, c.substeps);
        if (with_unused)
        begin
            write_reg(CFG_UNUSED_LO, $urandom);
            write_reg(CFG_UNUSED_HI, $urandom);
        end
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct = recv_pct;
    endtask

    // Extremes, zero, full random or a moderate magnitude that keeps the motor in range.
    function automatic logic [31:0] rand_coeff(input int bits, input bit is_signed);
        logic [31:0] v;
        case ($urandom_range(7))
            0:       v = is_signed ? 32'h8000_0000 : 32'h0000_0000;
            1:       v = 32'h7fff_ffff;
            2:       v = 32'h0000_0000;
            3:       v = $urandom;
            default:
            begin
                v = $urandom >> (32 - bits);
                if (is_signed && $urandom_range(1))
                begin
                    v = -v;
                end
            end
        endcase
        // The top bit of the unsigned registers is dropped by the block.
        if (!is_signed)
        begin
            v[31] = 1'($urandom_range(1));
        end
        return v;
    endfunction

    function automatic motor_cfg_t rand_motor_cfg();
        motor_cfg_t c;
        logic [7:0] n;
        c.gain = rand_coeff(26, 1'b1);
        c.friction = rand_coeff(25, 1'b1);
        c.inv_inertia = rand_coeff(26, 1'b0);
        c.step = rand_coeff(22, 1'b0);
        c.scale = rand_coeff(31, 1'b1);
        case ($urandom_range(8))
            0:       n = 8'd0;
            7:       n = 8'($urandom_range(20, 5));
            8:       n = 8'd255;
            default: n = 8'($urandom_range(4, 1));
        endcase
        c.substeps = ($urandom & 32'hffff_ff00) | {24'd0, n};
        return c;
    endfunction

    // Reset defaults: idle ticks, then commands at the current extremes.
    task automatic test_reset_defaults();
        set_idling(0, 0);
        drive_item(1'b0, 16'sd0);
        drive_item(1'b0, -16'sd1);
        drive_item(1'b1, 16'sh7fff);
        drive_item(1'b1, 16'sh8000);
        drive_item(1'b1, 16'sd0);
        drive_item(1'b1, 16'sd1);
        drive_item(1'b1, -16'sd1);
    endtask

    // Register extremes, saturation, zero substeps and writes to unused indexes.
    task automatic test_extremes();
        motor_cfg_t c;
        c = '{gain: 32'h7fff_ffff, friction: 32'h8000_0000, inv_inertia: 32'hffff_ffff,
              step: 32'hffff_ffff, scale: 32'h7fff_ffff, substeps: 32'h0000_00ff};
        load_motor_cfg(c, 1'b0);
        drive_item(1'b1, 16'sh7fff);
        drive_item(1'b1, 16'sh8000);
        drive_item(1'b0, 16'sh7fff);

        c = '{gain: 32'h8000_0000, friction: 32'h7fff_ffff, inv_inertia: 32'h0000_0000,
              step: 32'h0000_0000, scale: 32'h8000_0000, substeps: 32'hffff_ff02};
        load_motor_cfg(c, 1'b0);
        drive_item(1'b1, -16'sd1);
        drive_item(1'b1, 16'sh7fff);

        c = '{gain: 32'h0100_0000, friction: 32'h0000_0000, inv_inertia: 32'h0100_0000,
              step: 32'h0000_4189, scale: 32'h0100_0000, substeps: 32'h5a5a_5a00};
        load_motor_cfg(c, 1'b1);
        drive_item(1'b1, 16'sd1234);
        drive_item(1'b0, 16'sd0);
        drive_item(1'b1, 16'sh8000);
    endtask

    // Random configurations and items, cycling through the idling modes.
    task automatic test_random_traffic();
        motor_cfg_t c;
        int sent;
        int phase;
        int n_items;
        logic signed [15:0] cmd;
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case (phase % 4)
                0:       set_idling(0, 0);
                1:       set_idling(59, 0);
                2:       set_idling(0, 59);
                default: set_idling(14, 14);
            endcase
            c = rand_motor_cfg();
            load_motor_cfg(c, (phase % 5) == 0);
            // Long substep runs are slow, so those phases stay short.
            n_items = (c.substeps[7:0] > 8'd16) ? 4 : 25;
            repeat (n_items)
            begin
                cmd = 16'($urandom);
                drive_item($urandom_range(99) < 70, cmd);
            end
            sent += n_items;
            phase++;
        end
    endtask

    // The receiver holds off for a long stretch while items keep coming.
    task automatic test_backpressure();
        motor_cfg_t c;
        logic signed [15:0] cmd;
        c = '{gain: 32'h0200_0000, friction: 32'h0001_0000, inv_inertia: 32'h0080_0000,
              step: 32'h0004_0000, scale: 32'h0100_0000, substeps: 32'h0000_0002};
        load_motor_cfg(c, 1'b0);
        set_idling(0, 0);
        hold_req++;
        repeat (12)
        begin
            cmd = 16'($urandom);
            drive_item(1'($urandom_range(1)), cmd);
        end
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_ack <= 0;
        end
        else if (hold_ack != hold_req)
        begin
            hold_ack <= hold_req;
            hold_left <= HOLD_OFF_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Compare each accepted result against the oldest queued sample.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_samples.size() == 0)
            begin
                $error("result item with no input item pending");
                errors++;
            end
            else
            begin
                want_sample = pending_samples.pop_front();
                if (encoder_position !== want_sample.position)
                begin
                    $error("encoder_position: expected %0d, got %0d",
                           want_sample.position, encoder_position);
                    errors++;
                end
                if (encoder_velocity !== want_sample.velocity)
                begin
                    $error("encoder_velocity: expected %0d, got %0d",
                           want_sample.velocity, encoder_velocity);
                    errors++;
                end
                if (current_echo !== want_sample.echo)
                begin
                    $error("current_echo: expected %0d, got %0d",
                           want_sample.echo, current_echo);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        gain_q = TORQUE_GAIN_RST;
        friction_q = FRICTION_COEFF_RST;
        inv_inertia_q = INV_INERTIA_RST;
        step_q = TIME_STEP_RST;
        scale_q = ENCODER_SCALE_RST;
        substeps_q = SUBSTEPS_RST;
        rotor_vel = '0;
        rotor_pos = '0;
        last_cmd = '0;
        held_pos = '0;
        held_vel = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_extremes();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending_samples.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
